[rtl/skt_pkg.sv]
// Shared types, character codes and result codes for the series key tokenizer.
`timescale 1ns / 1ps

package skt_pkg;

   // Characters with a special meaning in a series key.
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_EQUALS = 8'h3D;

   // Role of the component a result belongs to.
   localparam logic [1:0] ROLE_LEADING   = 2'd0;
   localparam logic [1:0] ROLE_TAG_KEY   = 2'd1;
   localparam logic [1:0] ROLE_TAG_VALUE = 2'd2;
   localparam logic [1:0] ROLE_FIELD     = 2'd3;

   // Component close events.
   localparam logic [2:0] CLOSE_NONE          = 3'd0;
   localparam logic [2:0] CLOSE_MEASUREMENT   = 3'd1;
   localparam logic [2:0] CLOSE_TAG_KEPT      = 3'd2;
   localparam logic [2:0] CLOSE_TAG_DROPPED   = 3'd3;
   localparam logic [2:0] CLOSE_FIELD         = 3'd4;
   localparam logic [2:0] CLOSE_LEADING_FIELD = 3'd5;

   // Error codes.
   localparam logic [2:0] ERR_NONE           = 3'd0;
   localparam logic [2:0] ERR_EMPTY_KEY      = 3'd1;
   localparam logic [2:0] ERR_COMMA_IN_FIELD = 3'd2;
   localparam logic [2:0] ERR_SPACE_IN_FIELD = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED_QUOTE = 3'd4;

   typedef enum logic [1:0] {
      PART_LEADING,
      PART_TAGS,
      PART_FIELD
   } part_type;

   typedef struct packed {
      part_type part;
      logic     escape_pending;
      logic     in_quote;
      logic     seen_equals;
      logic     error_seen;
   } tok_state_type;

   localparam tok_state_type TOK_STATE_RESET = '{
      part:           PART_LEADING,
      escape_pending: 1'b0,
      in_quote:       1'b0,
      seen_equals:    1'b0,
      error_seen:     1'b0
   };

   typedef struct packed {
      logic       has_byte;
      logic [7:0] key_byte;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [1:0] role;
      logic [2:0] close_kind;
      logic [2:0] error_code;
      logic       out_last;
   } rsp_beat_type;

endpackage

[rtl/skt_if.sv]
// Valid/ready channel interfaces for the tokenizer's byte input and result output.
`timescale 1ns / 1ps

interface skt_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] key_byte;
   logic       last;

   modport source (output valid, output has_byte, output key_byte, output last, input ready);
   modport sink   (input valid, input has_byte, input key_byte, input last, output ready);
endinterface

interface skt_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic [1:0] role;
   logic [2:0] close_kind;
   logic [2:0] error_code;
   logic       out_last;

   modport source (output valid, output out_valid, output out_byte, output role,
                   output close_kind, output error_code, output out_last, input ready);
   modport sink   (input valid, input out_valid, input out_byte, input role,
                   input close_kind, input error_code, input out_last, output ready);
endinterface

[rtl/skt_step.sv]
// Per-byte tokenizer logic: next state and result from the current state and one input beat.
`timescale 1ns / 1ps

module skt_step (
   input  skt_pkg::tok_state_type state_ff,
   input  skt_pkg::req_beat_type  req,
   output skt_pkg::tok_state_type state_in,
   output skt_pkg::rsp_beat_type  rsp_in
);

   skt_pkg::tok_state_type nx;
   logic                   ov;
   logic [7:0]             ob;
   logic [1:0]             role;
   logic [2:0]             cl;
   logic [2:0]             err;
   logic                   is_delim;

   assign is_delim = (req.key_byte == skt_pkg::CH_COMMA) || (req.key_byte == skt_pkg::CH_SPACE);

   always_comb begin
      nx   = state_ff;
      ov   = 1'b0;
      ob   = 8'h00;
      cl   = skt_pkg::CLOSE_NONE;
      err  = skt_pkg::ERR_NONE;

      unique case (state_ff.part)
         skt_pkg::PART_LEADING: role = skt_pkg::ROLE_LEADING;
         skt_pkg::PART_TAGS: begin
            role = state_ff.seen_equals ? skt_pkg::ROLE_TAG_VALUE : skt_pkg::ROLE_TAG_KEY;
         end
         default: role = skt_pkg::ROLE_FIELD;
      endcase

      if (state_ff.error_seen) begin
         // Bytes after an error are dropped until the key's last beat.
         nx = state_ff;
      end else if (!req.has_byte) begin
         err           = skt_pkg::ERR_EMPTY_KEY;
         nx.error_seen = 1'b1;
      end else begin
         priority if (state_ff.escape_pending) begin
            nx.escape_pending = 1'b0;
            ov                = 1'b1;
            ob                = req.key_byte;
         end else if (req.key_byte == skt_pkg::CH_BSLASH) begin
            // A lone backslash at the very end is kept as a literal.
            if (req.last) begin
               ov = 1'b1;
               ob = req.key_byte;
            end else begin
               nx.escape_pending = 1'b1;
            end
         end else if (req.key_byte == skt_pkg::CH_QUOTE) begin
            nx.in_quote = ~state_ff.in_quote;
            ov          = 1'b1;
            ob          = req.key_byte;
         end else if (state_ff.part == skt_pkg::PART_TAGS && !state_ff.seen_equals &&
                      req.key_byte == skt_pkg::CH_EQUALS) begin
            // The tag split carries the '=' with no valid flag so it can be rebuilt later.
            nx.seen_equals = 1'b1;
            ob             = req.key_byte;
            role           = skt_pkg::ROLE_TAG_VALUE;
         end else if (state_ff.in_quote || !is_delim) begin
            ov = 1'b1;
            ob = req.key_byte;
         end else if (state_ff.part == skt_pkg::PART_LEADING) begin
            cl             = skt_pkg::CLOSE_MEASUREMENT;
            nx.part        = (req.key_byte == skt_pkg::CH_COMMA) ? skt_pkg::PART_TAGS
                                                                 : skt_pkg::PART_FIELD;
            nx.seen_equals = 1'b0;
         end else if (state_ff.part == skt_pkg::PART_TAGS) begin
            cl             = state_ff.seen_equals ? skt_pkg::CLOSE_TAG_KEPT
                                                  : skt_pkg::CLOSE_TAG_DROPPED;
            nx.seen_equals = 1'b0;
            if (req.key_byte == skt_pkg::CH_SPACE) begin
               nx.part = skt_pkg::PART_FIELD;
            end
         end else begin
            err           = (req.key_byte == skt_pkg::CH_COMMA) ? skt_pkg::ERR_COMMA_IN_FIELD
                                                                : skt_pkg::ERR_SPACE_IN_FIELD;
            nx.error_seen = 1'b1;
         end

         // The last beat closes whatever is still open, unless a quote is left open.
         if (req.last && !nx.error_seen && cl == skt_pkg::CLOSE_NONE) begin
            if (nx.in_quote) begin
               err = skt_pkg::ERR_UNCLOSED_QUOTE;
               ov  = 1'b0;
               ob  = 8'h00;
            end else begin
               cl = (nx.part == skt_pkg::PART_LEADING) ? skt_pkg::CLOSE_LEADING_FIELD
                                                       : skt_pkg::CLOSE_FIELD;
            end
         end
      end

      if (req.last) begin
         nx = skt_pkg::TOK_STATE_RESET;
      end
   end

   assign state_in           = nx;
   assign rsp_in.out_valid   = ov;
   assign rsp_in.out_byte    = ob;
   assign rsp_in.role        = role;
   assign rsp_in.close_kind  = cl;
   assign rsp_in.error_code  = err;
   assign rsp_in.out_last    = req.last;

endmodule

[rtl/series_key_tokenizer.sv]
// A result appears in the output register in the cycle after its byte beat is accepted.
// Throughput: one byte beat per cycle while results are taken; the only limit is the single output register,
// which is reloaded in the same cycle its current result is taken.
// Reset (synchronous, active high) returns the tokenizer to the leading component with no
// quote, escape or error pending, and empties the output register.
`timescale 1ns / 1ps

module series_key_tokenizer (
   input  logic             clock,
   input  logic             reset,
   skt_req_if.sink          req_chan,
   skt_rsp_if.source        rsp_chan
);

   skt_pkg::tok_state_type state_ff;
   skt_pkg::tok_state_type state_in;
   skt_pkg::req_beat_type  req_beat;
   skt_pkg::rsp_beat_type  rsp_ff;
   skt_pkg::rsp_beat_type  rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_beat.has_byte = req_chan.has_byte;
   assign req_beat.key_byte = req_chan.key_byte;
   assign req_beat.last     = req_chan.last;

   skt_step u_step (
      .state_ff (state_ff),
      .req      (req_beat),
      .state_in (state_in),
      .rsp_in   (rsp_in)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::TOK_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_valid  = rsp_ff.out_valid;
   assign rsp_chan.out_byte   = rsp_ff.out_byte;
   assign rsp_chan.role       = rsp_ff.role;
   assign rsp_chan.close_kind = rsp_ff.close_kind;
   assign rsp_chan.error_code = rsp_ff.error_code;
   assign rsp_chan.out_last   = rsp_ff.out_last;

endmodule

[rtl/skt_checker.sv]
// Port-level checks for the series key tokenizer, bound to the top level.
`timescale 1ns / 1ps

module skt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_has_byte,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_close_kind,
   input logic [2:0] rsp_error_code,
   input logic       rsp_out_last
);

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_error_code) && $stable(rsp_out_last))
      else $error("skt: stalled result beat changed");

   // An accepted beat shows up as the next result, carrying its last flag.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_out_last == $past(req_last))
      else $error("skt: accepted beat did not reach the output register");

   // An empty key beat reports the empty-key error, or nothing if an error is already pending.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_has_byte |=>
         rsp_error_code == skt_pkg::ERR_EMPTY_KEY ||
         (rsp_error_code == skt_pkg::ERR_NONE && rsp_close_kind == skt_pkg::CLOSE_NONE &&
          !rsp_out_valid))
      else $error("skt: empty key beat gave a wrong result");

   // Error results carry no byte and no close.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != skt_pkg::ERR_NONE |->
         !rsp_out_valid && rsp_out_byte == 8'h00 && rsp_close_kind == skt_pkg::CLOSE_NONE)
      else $error("skt: error result carries payload");

   // Field closes and the unclosed-quote error only happen on the key's last beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_close_kind == skt_pkg::CLOSE_FIELD ||
                    rsp_close_kind == skt_pkg::CLOSE_LEADING_FIELD ||
                    rsp_error_code == skt_pkg::ERR_UNCLOSED_QUOTE) |-> rsp_out_last)
      else $error("skt: end-of-key event without last");

endmodule

bind series_key_tokenizer skt_checker u_skt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_has_byte   (req_chan.has_byte),
   .req_last       (req_chan.last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_valid  (rsp_chan.out_valid),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_close_kind (rsp_chan.close_kind),
   .rsp_error_code (rsp_chan.error_code),
   .rsp_out_last   (rsp_chan.out_last)
);
